// ===== rtl/core/integer_to_ascii_radix_defines.svh =====
// ============================================================================
// integer_to_ascii_radix_defines
// Assertion macros used by the checker of the radix printer.
// ============================================================================
// The macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Same-cycle implication.
`define I2AR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define I2AR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/i2ar_pkg.sv =====
// ============================================================================
// i2ar_pkg
// Shared widths, format codes, control struct and digit-to-ASCII mapping.
// ============================================================================
package i2ar_pkg;

    localparam int VAL_W   = 64;              // input value width
    localparam int CMD_W   = 3;               // format code width
    localparam int CHAR_W  = 7;               // ASCII code width
    localparam int NIB_W   = 4;               // one digit slot
    localparam int NDIG    = 22;              // digit slots (octal worst case)
    localparam int DIG_W   = NDIG * NIB_W;    // digit register width
    localparam int BCD_DIG = 20;              // decimal digits of 2^64-1
    localparam int BCD_W   = BCD_DIG * NIB_W;
    localparam int CNT_W   = $clog2(VAL_W);
    localparam int REM_W   = $clog2(NDIG + 1);

    // Format codes
    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OCT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEXL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HEXU = 3'd4;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;       // '0'
    localparam logic [CHAR_W-1:0] CHR_UPPER = 7'h41 - 7'd10; // 'A' - 10
    localparam logic [CHAR_W-1:0] CHR_LOWER = 7'h61 - 7'd10; // 'a' - 10

    // Sequencer to digit unit and output stage
    typedef struct packed {
        logic load;     // take a new value into the unit
        logic dabble;   // one shift-and-add-3 step
        logic shift;    // drop the top digit slot
        logic emit;     // write the top digit to the output register
        logic last;     // emitted digit is the final one
        logic upper;    // uppercase hex letters
    } t_unit_ctl;

    function automatic logic [CHAR_W-1:0] digit_to_char(
        input logic [NIB_W-1:0] nib,
        input logic             upper
    );
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-NIB_W){1'b0}}, nib};
        if (nib < 4'd10) begin
            digit_to_char = CHR_ZERO + ext;
        end else if (upper) begin
            digit_to_char = CHR_UPPER + ext;
        end else begin
            digit_to_char = CHR_LOWER + ext;
        end
    endfunction

endpackage

// ===== rtl/core/integer_to_ascii_radix.sv =====
// ============================================================================
// integer_to_ascii_radix
// Prints a 64-bit value as ASCII digits in decimal, octal or hex.
// ============================================================================
// Input beat: s_axis_tdata carries the value, s_axis_tuser the format code
// (0 signed decimal magnitude, 1 unsigned decimal, 2 octal, 3 lower hex,
// 4 upper hex, other codes lower hex). Output beats carry one ASCII digit
// each, most significant first, no leading zeros, '0' for zero; m_axis_tlast
// marks the final digit. No minus sign is printed.
// One number is in flight at a time; s_axis_tready is high only when idle.
// Decimal runs 64 shift-and-add-3 steps of the shared BCD unit first, then
// every format walks all 22 digit slots once, one per cycle while the
// receiver does not stall: leading zero slots are dropped, the rest emitted.
// A new number is taken only once the last digit of the current one has
// been written to the output register.
// A stalled receiver holds the current digit in the output register and
// stalls digit emission; nothing is lost. Reset drops any number in flight,
// returns the sequencer to idle and clears the output valid flag.
module integer_to_ascii_radix
    import i2ar_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [63:0] value
    input  logic [2:0]   s_axis_tuser,   // [2:0] cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [6:0] digit_char, [7] zero
    output logic         m_axis_tlast
);

    t_unit_ctl         ctl;
    logic              idle;
    logic [NIB_W-1:0]  top;
    logic              out_free;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    assign out_free      = !r_valid || m_axis_tready;
    assign s_axis_tready = idle;

    i2ar_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .i_top      (top),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_ctl      (ctl)
    );

    i2ar_digit_unit u_unit (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_value (s_axis_tdata),
        .i_cmd   (s_axis_tuser),
        .o_top   (top)
    );

    // Output register: load a digit when free, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (ctl.emit) begin
            r_char <= digit_to_char(top, ctl.upper);
            r_last <= ctl.last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {1'b0, r_char};
    assign m_axis_tlast  = r_last;

endmodule

// ===== rtl/core/i2ar_digit_unit.sv =====
// ============================================================================
// i2ar_digit_unit
// Digit register with one shared step unit: load, BCD adjust-and-shift,
// and a one-slot left shift that brings the next digit to the top.
// ============================================================================
module i2ar_digit_unit
    import i2ar_pkg::*;
(
    input  logic             i_clk,
    input  t_unit_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_value,
    input  logic [CMD_W-1:0] i_cmd,
    output logic [NIB_W-1:0] o_top
);

    logic [VAL_W-1:0] r_bin, n_bin;
    logic [DIG_W-1:0] r_dig, n_dig;
    logic [VAL_W-1:0] mag;
    logic [DIG_W-1:0] oct_dig;
    logic [DIG_W-1:0] adj;

    // Magnitude of the value; only signed decimal negates
    always_comb begin
        if ((i_cmd == CMD_SDEC) && i_value[VAL_W-1]) begin
            mag = (~i_value) + 64'd1;
        end else begin
            mag = i_value;
        end
    end

    // Spread 3-bit octal digits over 4-bit slots; the top slot gets one bit
    always_comb begin
        oct_dig = '0;
        for (int i = 0; i < NDIG - 1; i++) begin
            oct_dig[i*NIB_W +: NIB_W] = {1'b0, i_value[i*3 +: 3]};
        end
        oct_dig[(NDIG-1)*NIB_W +: NIB_W] = {3'b000, i_value[VAL_W-1]};
    end

    // Add 3 to every BCD digit of 5 or more
    always_comb begin
        adj = r_dig;
        for (int i = 0; i < BCD_DIG; i++) begin
            if (r_dig[i*NIB_W +: NIB_W] >= 4'd5) begin
                adj[i*NIB_W +: NIB_W] = r_dig[i*NIB_W +: NIB_W] + 4'd3;
            end
        end
    end

    // Select the step
    always_comb begin
        n_bin = r_bin;
        n_dig = r_dig;
        if (i_ctl.load) begin
            n_bin = mag;
            if ((i_cmd == CMD_SDEC) || (i_cmd == CMD_UDEC)) begin
                n_dig = '0;
            end else if (i_cmd == CMD_OCT) begin
                n_dig = oct_dig;
            end else begin
                n_dig = {{(DIG_W-VAL_W){1'b0}}, i_value};
            end
        end else if (i_ctl.dabble) begin
            n_dig = {r_dig[DIG_W-1:BCD_W], adj[BCD_W-2:0], r_bin[VAL_W-1]};
            n_bin = {r_bin[VAL_W-2:0], 1'b0};
        end else if (i_ctl.shift) begin
            n_dig = {r_dig[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_dig <= n_dig;
    end

    assign o_top = r_dig[DIG_W-1 -: NIB_W];

endmodule

// ===== rtl/core/i2ar_seq.sv =====
// ============================================================================
// i2ar_seq
// Sequencer: binary-to-BCD steps for decimal, leading-zero skip, then digit emission.
// ============================================================================
module i2ar_seq
    import i2ar_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [NIB_W-1:0] i_top,
    input  logic             i_out_free,
    output logic             o_idle,
    output t_unit_ctl        o_ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DABBLE = 2'd1;
    localparam logic [1:0] S_SKIP   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_upper, n_upper;

    // Next state and unit controls
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_upper = r_upper;
        o_ctl   = '0;
        o_ctl.upper = r_upper;
        o_ctl.last  = (r_rem == REM_W'(1));
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_upper    = (i_cmd == CMD_HEXU);
                    n_rem      = REM_W'(NDIG);
                    n_cnt      = CNT_W'(VAL_W - 1);
                    if ((i_cmd == CMD_SDEC) || (i_cmd == CMD_UDEC)) begin
                        n_state = S_DABBLE;
                    end else begin
                        n_state = S_SKIP;
                    end
                end
            end
            S_DABBLE: begin
                o_ctl.dabble = 1'b1;
                n_cnt        = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if ((i_top == '0) && (r_rem != REM_W'(1))) begin
                    o_ctl.shift = 1'b1;
                    n_rem       = r_rem - REM_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_ctl.emit  = 1'b1;
                    o_ctl.shift = 1'b1;
                    n_rem       = r_rem - REM_W'(1);
                    if (r_rem == REM_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_upper <= n_upper;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== rtl/core/i2ar_checker.sv =====
// ============================================================================
// i2ar_checker
// Port-level checks of the radix printer, bound to the top level.
// ============================================================================
`include "integer_to_ascii_radix_defines.svh"

module i2ar_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Every digit beat is a digit or letter code from '0' to 'f'
    `I2AR_ASSERT_SAME(a_char_range, m_axis_tvalid, (m_axis_tdata >= 8'h30) && (m_axis_tdata <= 8'h66), "digit beat outside ASCII digit range")

    // A number still being emitted keeps the input closed
    `I2AR_ASSERT_SAME(a_busy_mid, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input open before last digit")

    // An accepted number closes the input for the next cycle
    `I2AR_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open right after accept")

    // A stalled digit beat holds
    `I2AR_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled digit beat changed")

endmodule

bind integer_to_ascii_radix i2ar_checker u_i2ar_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
